// ----- src/nearest_centroid_confusion_counter_assert.svh -----
// Assertion macros for the nearest-centroid confusion counter.
`ifndef NEAREST_CENTROID_CONFUSION_COUNTER_ASSERT_SVH
`define NEAREST_CENTROID_CONFUSION_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define NCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ncc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define NCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ncc assertion failed");

`endif

// ----- src/ncc_pkg.sv -----
// Shared constants, request codes and types of the nearest-centroid confusion counter.
package ncc_pkg;

    localparam int NUM_CLASSES_DEF = 6;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int REQ_W      = 2;
    localparam int IDX_IN_W   = 3;
    localparam int WIN_OUT_W  = 3;
    localparam int DIST_OUT_W = 26;
    localparam int CNT_OUT_W  = 16;

    localparam logic [REQ_W-1:0] REQ_LOAD     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLASSIFY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ     = 2'd3;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_mem_cmd;

endpackage

// ----- src/ncc_cell.sv -----
// One chain cell: holds a centroid and folds its distance into the running best.
module ncc_cell
    import ncc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IDX_W       = 3,
    parameter int CELL_INDEX  = 0,
    localparam int DIST_W     = 2 * SAMPLE_BITS + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [SAMPLE_BITS-1:0] i_x,
    input  logic [SAMPLE_BITS-1:0] i_y,
    input  logic [SAMPLE_BITS-1:0] i_z,
    input  logic                   i_vld,
    input  logic [DIST_W-1:0]      i_dist,
    input  logic [IDX_W-1:0]       i_idx,
    output logic                   o_vld,
    output logic [DIST_W-1:0]      o_dist,
    output logic [IDX_W-1:0]       o_idx
);

    localparam int SQ_W = 2 * SAMPLE_BITS;

    logic [SAMPLE_BITS-1:0] r_cx, r_cy, r_cz;
    logic [SQ_W-1:0]        r_sq_x, r_sq_y, r_sq_z;
    logic                   r_a_vld, r_b_vld;
    logic [DIST_W-1:0]      r_a_dist, r_b_dist;
    logic [IDX_W-1:0]       r_a_idx, r_b_idx;
    logic [SAMPLE_BITS-1:0] w_dx, w_dy, w_dz;
    logic [DIST_W-1:0]      n_sum;

    assign w_dx = (i_x > r_cx) ? i_x - r_cx : r_cx - i_x;
    assign w_dy = (i_y > r_cy) ? i_y - r_cy : r_cy - i_y;
    assign w_dz = (i_z > r_cz) ? i_z - r_cz : r_cz - i_z;

    assign n_sum = DIST_W'(r_sq_x) + DIST_W'(r_sq_y) + DIST_W'(r_sq_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_cz    <= '0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (i_load) begin
                r_cx <= i_x;
                r_cy <= i_y;
                r_cz <= i_z;
            end
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
    end

    // stage A: squares of the axis differences
    always_ff @(posedge i_clk) begin
        r_sq_x   <= SQ_W'(w_dx) * SQ_W'(w_dx);
        r_sq_y   <= SQ_W'(w_dy) * SQ_W'(w_dy);
        r_sq_z   <= SQ_W'(w_dz) * SQ_W'(w_dz);
        r_a_dist <= i_dist;
        r_a_idx  <= i_idx;
    end

    // stage B: strict compare keeps the lower index on a tie
    always_ff @(posedge i_clk) begin
        if (n_sum < r_a_dist) begin
            r_b_dist <= n_sum;
            r_b_idx  <= IDX_W'(CELL_INDEX);
        end else begin
            r_b_dist <= r_a_dist;
            r_b_idx  <= r_a_idx;
        end
    end

    assign o_vld  = r_b_vld;
    assign o_dist = r_b_dist;
    assign o_idx  = r_b_idx;

endmodule

// ----- src/ncc_count_mem.sv -----
// Confusion counter store: single-port memory with per-entry valid bits for clearing.
module ncc_count_mem
    import ncc_pkg::*;
#(
    parameter int DEPTH   = NUM_CLASSES_DEF * NUM_CLASSES_DEF,
    parameter int DATA_W  = COUNT_BITS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_cmd          i_cmd,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [DATA_W-1:0] r_rdata;
    logic              r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    // an entry not written since the last clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_vld <= '0;
            end else if (i_cmd.wr) begin
                r_vld[i_addr] <= 1'b1;
            end
            if (i_cmd.rd) begin
                r_rvld <= r_vld[i_addr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// ----- src/nearest_centroid_confusion_counter.sv -----
// Top level: nearest-centroid classifier with saturating confusion counters.
//
// Input channel (i_in_valid / o_in_stall) carries one request per transaction:
// load a centroid, classify and count, clear all counters, or read a counter.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// request, in request order. One request is worked on at a time.
// Classify: the sample runs down a chain of NUM_CLASSES cells, each of which
// registers the squares of the axis differences, then adds and compares; the
// chain is followed by a counter read and a write-back.
// Load and clear go from idle straight to the done state, read by way of the
// read state; the done state then loads the registered result.
// The next request is taken the cycle after the result is registered, even
// while that result is still held back by the receiver.
// A stalled result holds in the output register; a further result waits in
// its final state until the register frees.
// Reset zeroes every centroid and marks every counter as zero at once.
module nearest_centroid_confusion_counter
    import ncc_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [REQ_W-1:0]       i_req_type,
    input  logic [IDX_IN_W-1:0]    i_center_index,
    input  logic [SAMPLE_BITS-1:0] i_sample_x,
    input  logic [SAMPLE_BITS-1:0] i_sample_y,
    input  logic [SAMPLE_BITS-1:0] i_sample_z,
    input  logic [IDX_IN_W-1:0]    i_true_class,
    input  logic [IDX_IN_W-1:0]    i_read_column,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [WIN_OUT_W-1:0]   o_winner,
    output logic [DIST_OUT_W-1:0]  o_best_distance_sq,
    output logic [CNT_OUT_W-1:0]   o_count_value
);

`include "nearest_centroid_confusion_counter_assert.svh"

    localparam int DIST_W  = 2 * SAMPLE_BITS + 2;
    localparam int IDX_W   = $clog2(NUM_CLASSES);
    localparam int DEPTH   = NUM_CLASSES * NUM_CLASSES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DEXT_W  = (DIST_W > DIST_OUT_W) ? DIST_W : DIST_OUT_W;
    localparam int CEXT_W  = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
    localparam logic [DEXT_W-1:0] DIST_SAT = DEXT_W'({DIST_OUT_W{1'b1}});
    localparam logic [CEXT_W-1:0] CNT_SAT  = CEXT_W'({CNT_OUT_W{1'b1}});

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHAIN = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]             r_state;
    logic [REQ_W-1:0]       r_req;
    logic [IDX_IN_W-1:0]    r_row, r_col;
    logic [SAMPLE_BITS-1:0] r_sx, r_sy, r_sz;
    logic                   r_launch;
    logic [NUM_CLASSES-1:0] r_ld_we;
    logic [NUM_CLASSES-1:0] n_ld_we;
    logic [IDX_W-1:0]       r_win;
    logic [DIST_W-1:0]      r_best;
    logic [COUNT_BITS-1:0]  r_cnt;
    logic                   r_out_valid;
    logic [WIN_OUT_W-1:0]   r_o_win;
    logic [DIST_OUT_W-1:0]  r_o_dist;
    logic [CNT_OUT_W-1:0]   r_o_cnt;

    logic                   w_in_acc;
    logic                   w_out_free;
    logic                   w_row_ok, w_col_ok, w_in_rc_ok;
    t_mem_cmd               w_cmd;
    logic [ADDR_W-1:0]      w_addr;
    logic [COUNT_BITS-1:0]  w_rdata, w_inc;
    logic [DEXT_W-1:0]      w_dext;
    logic [CEXT_W-1:0]      w_cext;

    logic                   w_tok_vld  [NUM_CLASSES+1];
    logic [DIST_W-1:0]      w_tok_dist [NUM_CLASSES+1];
    logic [IDX_W-1:0]       w_tok_idx  [NUM_CLASSES+1];

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_row_ok   = int'(r_row) < NUM_CLASSES;
    assign w_col_ok   = int'(r_col) < NUM_CLASSES;
    assign w_in_rc_ok = (int'(i_true_class) < NUM_CLASSES)
                     && (int'(i_read_column) < NUM_CLASSES);

    // the chain head starts above any real distance so cell 0 always takes it
    assign w_tok_vld[0]  = r_launch;
    assign w_tok_dist[0] = '1;
    assign w_tok_idx[0]  = '0;

    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cell
        ncc_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .IDX_W       (IDX_W),
            .CELL_INDEX  (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (r_ld_we[g]),
            .i_x     (r_sx),
            .i_y     (r_sy),
            .i_z     (r_sz),
            .i_vld   (w_tok_vld[g]),
            .i_dist  (w_tok_dist[g]),
            .i_idx   (w_tok_idx[g]),
            .o_vld   (w_tok_vld[g+1]),
            .o_dist  (w_tok_dist[g+1]),
            .o_idx   (w_tok_idx[g+1])
        );
    end

    ncc_count_mem #(
        .DEPTH  (DEPTH),
        .DATA_W (COUNT_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_addr  (w_addr),
        .i_wdata (w_inc),
        .o_rdata (w_rdata)
    );

    assign w_inc = (w_rdata == '1) ? w_rdata : w_rdata + COUNT_BITS'(1);

    always_comb begin
        w_cmd  = '0;
        w_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_req_type == REQ_CLEAR) begin
                    w_cmd.clr = 1'b1;
                end
                if (w_in_acc && i_req_type == REQ_READ && w_in_rc_ok) begin
                    w_cmd.rd = 1'b1;
                    w_addr   = ADDR_W'(int'(i_true_class) * NUM_CLASSES
                                       + int'(i_read_column));
                end
            end
            S_CHAIN: begin
                if (w_tok_vld[NUM_CLASSES] && w_row_ok) begin
                    w_cmd.rd = 1'b1;
                    w_addr   = ADDR_W'(int'(r_row) * NUM_CLASSES
                                       + int'(w_tok_idx[NUM_CLASSES]));
                end
            end
            S_READ: begin
                if (r_req == REQ_CLASSIFY && w_row_ok) begin
                    w_cmd.wr = 1'b1;
                    w_addr   = ADDR_W'(int'(r_row) * NUM_CLASSES + int'(r_win));
                end
            end
            default: begin
            end
        endcase
    end

    // one-hot centroid write strobe; an out-of-range slot selects nothing
    always_comb begin
        n_ld_we = '0;
        if (w_in_acc && i_req_type == REQ_LOAD) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                n_ld_we[k] = (int'(i_center_index) == k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
            r_ld_we  <= '0;
        end else begin
            r_launch <= w_in_acc && (i_req_type == REQ_CLASSIFY);
            r_ld_we  <= n_ld_we;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_req_type)
                            REQ_CLASSIFY: begin
                                r_state <= S_CHAIN;
                            end
                            REQ_READ: begin
                                r_state <= S_READ;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CHAIN: begin
                    if (w_tok_vld[NUM_CLASSES]) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // transaction payload and working results
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_req  <= i_req_type;
                    r_row  <= i_true_class;
                    r_col  <= i_read_column;
                    r_sx   <= i_sample_x;
                    r_sy   <= i_sample_y;
                    r_sz   <= i_sample_z;
                    r_win  <= '0;
                    r_best <= '0;
                    r_cnt  <= '0;
                end
            end
            S_CHAIN: begin
                if (w_tok_vld[NUM_CLASSES]) begin
                    r_win  <= w_tok_idx[NUM_CLASSES];
                    r_best <= w_tok_dist[NUM_CLASSES];
                end
            end
            S_READ: begin
                if (r_req == REQ_CLASSIFY) begin
                    r_cnt <= w_row_ok ? w_inc : '0;
                end else begin
                    r_cnt <= (w_row_ok && w_col_ok) ? w_rdata : '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_dext = DEXT_W'(r_best);
    assign w_cext = CEXT_W'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_o_win  <= WIN_OUT_W'(r_win);
            r_o_dist <= (w_dext > DIST_SAT) ? DIST_OUT_W'(DIST_SAT)
                                            : DIST_OUT_W'(w_dext);
            r_o_cnt  <= (w_cext > CNT_SAT) ? CNT_OUT_W'(CNT_SAT)
                                           : CNT_OUT_W'(w_cext);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_winner           = r_o_win;
    assign o_best_distance_sq = r_o_dist;
    assign o_count_value      = r_o_cnt;

    `NCC_ASSERT_NOW(a_chain_out_in_chain_state, i_clk, i_rst_n,
        w_tok_vld[NUM_CLASSES], r_state == S_CHAIN)
    `NCC_ASSERT_NOW(a_count_write_only_on_classify, i_clk, i_rst_n,
        w_cmd.wr, r_state == S_READ && r_req == REQ_CLASSIFY && !w_cmd.rd)
    `NCC_ASSERT_NEXT(a_single_launch, i_clk, i_rst_n,
        r_launch, !r_launch && r_state == S_CHAIN)

endmodule

// ----- tb/sv/tb_nearest_centroid_confusion_counter.sv -----
// Self-checking testbench for the nearest-centroid confusion counter.
`timescale 1ns / 100ps

module tb_nearest_centroid_confusion_counter;
    import ncc_pkg::*;

    localparam int NUM_CLASSES = NUM_CLASSES_DEF;
    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int COUNT_BITS  = COUNT_BITS_DEF;
    localparam int COORD_MAX   = 2**SAMPLE_BITS - 1;
    localparam longint unsigned COUNT_MAX = 2**COUNT_BITS - 1;
    localparam longint unsigned DIST_MAX  = 2**DIST_OUT_W - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 440;
    localparam int TAIL_ITEMS     = 30;

    typedef struct packed {
        logic [REQ_W-1:0]       kind;
        logic [IDX_IN_W-1:0]    center;
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
        logic [SAMPLE_BITS-1:0] z;
        logic [IDX_IN_W-1:0]    row;
        logic [IDX_IN_W-1:0]    col;
    } t_ncc_request;

    typedef struct packed {
        logic [WIN_OUT_W-1:0]  winner;
        logic [DIST_OUT_W-1:0] dist_sq;
        logic [CNT_OUT_W-1:0]  count;
    } t_ncc_result;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_stall;
    logic [REQ_W-1:0]       i_req_type     = REQ_LOAD;
    logic [IDX_IN_W-1:0]    i_center_index = '0;
    logic [SAMPLE_BITS-1:0] i_sample_x     = '0;
    logic [SAMPLE_BITS-1:0] i_sample_y     = '0;
    logic [SAMPLE_BITS-1:0] i_sample_z     = '0;
    logic [IDX_IN_W-1:0]    i_true_class   = '0;
    logic [IDX_IN_W-1:0]    i_read_column  = '0;
    logic                   o_out_valid;
    logic                   i_out_stall    = 1'b0;
    logic [WIN_OUT_W-1:0]   o_winner;
    logic [DIST_OUT_W-1:0]  o_best_distance_sq;
    logic [CNT_OUT_W-1:0]   o_count_value;

    // Shadow state of the block
    logic [SAMPLE_BITS-1:0] cent_x [NUM_CLASSES] = '{default: '0};
    logic [SAMPLE_BITS-1:0] cent_y [NUM_CLASSES] = '{default: '0};
    logic [SAMPLE_BITS-1:0] cent_z [NUM_CLASSES] = '{default: '0};
    longint unsigned conf_count [NUM_CLASSES][NUM_CLASSES] = '{default: '{default: 0}};

    t_ncc_result pending_results [$];
    int          error_count  = 0;
    int          idle_cycles  = 0;
    int          stall_left   = 0;
    bit          quiet_mode   = 1'b0;

    nearest_centroid_confusion_counter #(
        .NUM_CLASSES (NUM_CLASSES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_req_type         (i_req_type),
        .i_center_index     (i_center_index),
        .i_sample_x         (i_sample_x),
        .i_sample_y         (i_sample_y),
        .i_sample_z         (i_sample_z),
        .i_true_class       (i_true_class),
        .i_read_column      (i_read_column),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_winner           (o_winner),
        .o_best_distance_sq (o_best_distance_sq),
        .o_count_value      (o_count_value)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint unsigned centroid_distance(t_ncc_request rq, int idx);
        longint unsigned dx, dy, dz;
        dx = (rq.x > cent_x[idx]) ? rq.x - cent_x[idx] : cent_x[idx] - rq.x;
        dy = (rq.y > cent_y[idx]) ? rq.y - cent_y[idx] : cent_y[idx] - rq.y;
        dz = (rq.z > cent_z[idx]) ? rq.z - cent_z[idx] : cent_z[idx] - rq.z;
        return dx * dx + dy * dy + dz * dz;
    endfunction

    // Applies one request to the shadow state and returns the result it yields
    function automatic t_ncc_result centroid_counter_response(t_ncc_request rq);
        t_ncc_result     res;
        longint unsigned best, d;
        int              win;
        res = '0;
        case (rq.kind)
            REQ_LOAD: begin
                if (rq.center < NUM_CLASSES) begin
                    cent_x[rq.center] = rq.x;
                    cent_y[rq.center] = rq.y;
                    cent_z[rq.center] = rq.z;
                end
            end
            REQ_CLASSIFY: begin
                best = centroid_distance(rq, 0);
                win  = 0;
                for (int i = 1; i < NUM_CLASSES; i++) begin
                    d = centroid_distance(rq, i);
                    // strict compare: lowest index keeps a tie
                    if (d < best) begin
                        best = d;
                        win  = i;
                    end
                end
                res.winner  = WIN_OUT_W'(win);
                res.dist_sq = DIST_OUT_W'((best > DIST_MAX) ? DIST_MAX : best);
                if (rq.row < NUM_CLASSES) begin
                    if (conf_count[rq.row][win] < COUNT_MAX)
                        conf_count[rq.row][win]++;
                    res.count = CNT_OUT_W'(conf_count[rq.row][win]);
                end
            end
            REQ_CLEAR: begin
                conf_count = '{default: '{default: 0}};
            end
            REQ_READ: begin
                if (rq.row < NUM_CLASSES && rq.col < NUM_CLASSES)
                    res.count = CNT_OUT_W'(conf_count[rq.row][rq.col]);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic void note_failure(string msg);
        error_count++;
        if (error_count <= 10)
            $display("mismatch: %s", msg);
    endfunction

    // Prediction on each accepted request, comparison on each accepted result
    always @(posedge i_clk) begin
        t_ncc_request rq;
        t_ncc_result  exp_r;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            rq = '{i_req_type, i_center_index, i_sample_x, i_sample_y, i_sample_z,
                   i_true_class, i_read_column};
            pending_results.push_back(centroid_counter_response(rq));
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result winner %0d dist %0d count %0d",
                                       o_winner, o_best_distance_sq, o_count_value));
            end else begin
                exp_r = pending_results.pop_front();
                if (o_winner !== exp_r.winner)
                    note_failure($sformatf("winner exp %0d got %0d", exp_r.winner, o_winner));
                if (o_best_distance_sq !== exp_r.dist_sq)
                    note_failure($sformatf("best_distance_sq exp %0d got %0d",
                                           exp_r.dist_sq, o_best_distance_sq));
                if (o_count_value !== exp_r.count)
                    note_failure($sformatf("count_value exp %0d got %0d",
                                           exp_r.count, o_count_value));
            end
        end
    end

    // Result-side back-pressure in bursts
    always @(posedge i_clk) begin
        if (quiet_mode || !i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 5);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Ends the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_ncc_request make_request(logic [REQ_W-1:0] kind, int center,
                                                  int x, int y, int z, int row, int col);
        t_ncc_request rq;
        rq.kind   = kind;
        rq.center = IDX_IN_W'(center);
        rq.x      = SAMPLE_BITS'(x);
        rq.y      = SAMPLE_BITS'(y);
        rq.z      = SAMPLE_BITS'(z);
        rq.row    = IDX_IN_W'(row);
        rq.col    = IDX_IN_W'(col);
        return rq;
    endfunction

    // Presents one transaction and returns on the edge that accepts it
    task automatic send_request(t_ncc_request rq);
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= rq.kind;
        i_center_index <= rq.center;
        i_sample_x     <= rq.x;
        i_sample_y     <= rq.y;
        i_sample_z     <= rq.z;
        i_true_class   <= rq.row;
        i_read_column  <= rq.col;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Centroids still at reset: everything ties at index 0
    task automatic test_unloaded_centroids();
        send_request(make_request(REQ_CLASSIFY, 0, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0));
        send_request(make_request(REQ_CLASSIFY, 0, 0, 0, 0, 5, 0));
        send_request(make_request(REQ_READ, 0, 0, 0, 0, 0, 0));
        send_request(make_request(REQ_READ, 0, 0, 0, 0, 6, 0));
        send_request(make_request(REQ_READ, 0, 0, 0, 0, 0, 7));
    endtask

    task automatic test_load_and_ties();
        send_request(make_request(REQ_LOAD, 0, 0, 0, 0, 0, 0));
        send_request(make_request(REQ_LOAD, 1, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0));
        send_request(make_request(REQ_LOAD, 2, 2048, 0, COORD_MAX, 0, 0));
        send_request(make_request(REQ_LOAD, 3, 1000, 1000, 1000, 0, 0));
        send_request(make_request(REQ_LOAD, 4, 1002, 1000, 1000, 0, 0));
        send_request(make_request(REQ_LOAD, 5, 2048, 0, COORD_MAX, 0, 0));
        // slots 6 and 7 do not exist; these loads must leave the store alone
        send_request(make_request(REQ_LOAD, 6, 1001, 1000, 1000, 0, 0));
        send_request(make_request(REQ_LOAD, 7, 1001, 1000, 1000, 0, 0));
        // equidistant from 3 and 4, lower index wins
        send_request(make_request(REQ_CLASSIFY, 0, 1001, 1000, 1000, 1, 0));
        // exact hit on duplicated centroids 2 and 5
        send_request(make_request(REQ_CLASSIFY, 0, 2048, 0, COORD_MAX, 4, 0));
        send_request(make_request(REQ_CLASSIFY, 0, COORD_MAX, COORD_MAX, COORD_MAX, 6, 0));
        send_request(make_request(REQ_CLASSIFY, 0, 0, 0, 0, 7, 0));
        send_request(make_request(REQ_READ, 0, 0, 0, 0, 1, 3));
    endtask

    task automatic test_clear_counters();
        send_request(make_request(REQ_READ, 0, 0, 0, 0, 4, 2));
        send_request(make_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
        send_request(make_request(REQ_READ, 0, 0, 0, 0, 4, 2));
    endtask

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    task automatic test_random_traffic();
        t_ncc_request rq;
        int           pick, src, spread;
        repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            src  = $urandom_range(0, NUM_CLASSES - 1);
            rq   = make_request(REQ_CLASSIFY, $urandom_range(0, 7),
                                $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                $urandom_range(0, COORD_MAX),
                                ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7)
                                                            : $urandom_range(0, 5),
                                $urandom_range(0, 7));
            if (pick < 10) begin
                rq.kind = REQ_LOAD;
                // copying another centroid makes exact ties
                if ($urandom_range(0, 3) == 0) begin
                    rq.x = cent_x[src];
                    rq.y = cent_y[src];
                    rq.z = cent_z[src];
                end
            end else if (pick < 80) begin
                spread = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 300);
                if ($urandom_range(0, 4) != 0) begin
                    rq.x = SAMPLE_BITS'(clamp_coord(int'(cent_x[src])
                                        + $urandom_range(0, 2 * spread) - spread));
                    rq.y = SAMPLE_BITS'(clamp_coord(int'(cent_y[src])
                                        + $urandom_range(0, 2 * spread) - spread));
                    rq.z = SAMPLE_BITS'(clamp_coord(int'(cent_z[src])
                                        + $urandom_range(0, 2 * spread) - spread));
                end
            end else if (pick < 82) begin
                rq.kind = REQ_CLEAR;
            end else begin
                rq.kind = REQ_READ;
                if ($urandom_range(0, 9) != 0)
                    rq.col = IDX_IN_W'($urandom_range(0, 5));
            end
            send_request(rq);
        end
    endtask

    // Back-to-back counting on one cell, no idling on either side
    task automatic test_back_to_back_tail();
        quiet_mode = 1'b1;
        send_request(make_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
        repeat (TAIL_ITEMS)
            send_request(make_request(REQ_CLASSIFY, 0, 1234, 567, 3210, 2, 0));
        for (int c = 0; c < NUM_CLASSES; c++)
            send_request(make_request(REQ_READ, 0, 0, 0, 0, 2, c));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unloaded_centroids();
        test_load_and_ties();
        test_clear_counters();
        test_random_traffic();
        test_back_to_back_tail();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- nearest_centroid_confusion_counter.f -----
+incdir+src
src/ncc_pkg.sv
src/ncc_cell.sv
src/ncc_count_mem.sv
src/nearest_centroid_confusion_counter.sv
tb/sv/tb_nearest_centroid_confusion_counter.sv
